// ===== design/sdfr_pkg.sv =====
//------------------------------------------------------------------------------
// sdfr_pkg
// Shared types and constants for the serial dongle frame receiver.
//------------------------------------------------------------------------------
`default_nettype none
package sdfr_pkg;
  localparam int BufferBytesDefault = 64;

  localparam logic [7:0] SYNC_BYTE  = 8'hFF;
  localparam logic [7:0] CMD_DATA   = 8'h03;
  localparam logic [7:0] CMD_ACK    = 8'h89;
  localparam logic [7:0] CMD_SERIAL = 8'h8B;
  localparam logic [7:0] PRESET_PREFIX_XOR = 8'hFF ^ 8'h09 ^ 8'h03 ^ 8'h46 ^ 8'h01;
  localparam logic [15:0] VALID_MODES = 16'h0DEE;
  localparam int RESULT_CAP = 60;

  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;

  localparam logic [2:0] KIND_PAYLOAD = 3'd0;
  localparam logic [2:0] KIND_PRESET  = 3'd1;
  localparam logic [2:0] KIND_IDREQ   = 3'd2;
  localparam logic [2:0] KIND_READY   = 3'd3;
  localparam logic [2:0] KIND_FAILED  = 3'd4;
  localparam logic [2:0] KIND_DROPPED = 3'd5;
  localparam logic [2:0] KIND_FORMAT  = 3'd6;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_FORMAT = 3'd1;
  localparam logic [2:0] PH_MODE   = 3'd2;
  localparam logic [2:0] PH_ID     = 3'd3;
  localparam logic [2:0] PH_READY  = 3'd4;

  // controller -> datapath commands
  typedef struct packed {
    logic clear;        // empty the store
    logic push;         // append the accepted byte
    logic rd_en;        // read store at rd_addr (relative to head)
    logic drop_en;      // advance head by drop_cnt
    logic drop_frame;   // drop = frame length, else drop one byte
    logic drop_scan;    // drop = scan position
    logic cs_clr;       // reset checksum accumulator
    logic cs_acc;       // xor read data into checksum
  } sdfr_cmd_t;
endpackage
`default_nettype wire

// ===== design/sdfr_datapath.sv =====
//------------------------------------------------------------------------------
// sdfr_datapath
// Circular frame store with head pointer and fill count, plus the check
// accumulator.
//------------------------------------------------------------------------------
`default_nettype none
module sdfr_datapath #(
  parameter int BUFFER_BYTES = sdfr_pkg::BufferBytesDefault,
  localparam int AW = $clog2(BUFFER_BYTES),
  localparam int CW = $clog2(BUFFER_BYTES + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire sdfr_pkg::sdfr_cmd_t cmd,
  input  wire logic [7:0]       wr_byte,
  input  wire logic [CW-1:0]    rd_addr,
  input  wire logic [CW-1:0]    scan_pos,
  input  wire logic [8:0]       frame_len,
  output logic [7:0]            rd_data,
  output logic [CW-1:0]         fill,
  output logic [7:0]            cs
);
  import sdfr_pkg::*;

  logic [7:0]    mem [BUFFER_BYTES];
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [7:0]    cs_r;
  logic [CW-1:0] drop_cnt;
  logic [AW:0]   wsum, rsum, dsum;
  logic [AW-1:0] waddr, raddr;

  assign fill = fill_r;
  assign cs   = cs_r;

  // head + offset modulo depth; depth need not be a power of two
  always_comb begin
    wsum = {1'b0, head_r} + (AW+1)'(fill_r);
    if (wsum >= (AW+1)'(BUFFER_BYTES)) wsum = wsum - (AW+1)'(BUFFER_BYTES);
    waddr = wsum[AW-1:0];
    rsum = {1'b0, head_r} + (AW+1)'(rd_addr);
    if (rsum >= (AW+1)'(BUFFER_BYTES)) rsum = rsum - (AW+1)'(BUFFER_BYTES);
    raddr = rsum[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.push && fill_r < CW'(BUFFER_BYTES)) mem[waddr] <= wr_byte;
    if (cmd.rd_en) rd_data <= mem[raddr];
  end

  always_comb begin
    if (cmd.drop_frame)     drop_cnt = (frame_len >= 9'(fill_r)) ? fill_r : CW'(frame_len);
    else if (cmd.drop_scan) drop_cnt = scan_pos;
    else                    drop_cnt = CW'(1);
    dsum = {1'b0, head_r} + (AW+1)'(drop_cnt);
    if (dsum >= (AW+1)'(BUFFER_BYTES)) dsum = dsum - (AW+1)'(BUFFER_BYTES);
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (cmd.clear) begin
      fill_nxt = '0;
    end else if (cmd.push) begin
      if (fill_r < CW'(BUFFER_BYTES)) fill_nxt = fill_r + CW'(1);
    end else if (cmd.drop_en) begin
      if (drop_cnt >= fill_r) begin
        fill_nxt = '0;
      end else begin
        fill_nxt = fill_r - drop_cnt;
        head_nxt = dsum[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cs_clr)      cs_r <= '0;
    else if (cmd.cs_acc) cs_r <= cs_r ^ rd_data;
  end
endmodule
`default_nettype wire

// ===== design/sdfr_ctrl.sv =====
//------------------------------------------------------------------------------
// sdfr_ctrl
// Sequencer: accepts requests, runs resync scan, check pass and result emission.
//------------------------------------------------------------------------------
`default_nettype none
module sdfr_ctrl #(
  parameter int BUFFER_BYTES = sdfr_pkg::BufferBytesDefault,
  localparam int CW = $clog2(BUFFER_BYTES + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    in_req_type,
  input  wire logic [7:0]    in_rx_byte,
  input  wire logic [3:0]    mode,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [2:0]         out_kind,
  output logic [7:0]         out_data_byte,
  output logic [31:0]        out_serial_number,
  output logic               out_last,
  output sdfr_pkg::sdfr_cmd_t cmd,
  output logic [7:0]         wr_byte,
  output logic [CW-1:0]      rd_addr,
  output logic [CW-1:0]      scan_pos,
  output logic [8:0]         frame_len,
  input  wire logic [7:0]    rd_data,
  input  wire logic [CW-1:0] fill,
  input  wire logic [7:0]    cs
);
  import sdfr_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HEAD  = 4'd1;  // read head byte
  localparam logic [3:0] S_HCHK  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;  // read byte at scan_pos
  localparam logic [3:0] S_SCHK  = 4'd4;
  localparam logic [3:0] S_LEN   = 4'd5;  // wait read of length
  localparam logic [3:0] S_CSUM  = 4'd6;  // accumulate check
  localparam logic [3:0] S_CMD   = 4'd7;
  localparam logic [3:0] S_ST    = 4'd8;  // ack status byte check
  localparam logic [3:0] S_EMIT  = 4'd9;  // payload byte read in flight
  localparam logic [3:0] S_OUT   = 4'd10; // result waiting
  localparam logic [3:0] S_SNRD  = 4'd11;
  localparam logic [3:0] S_DROP  = 4'd12;

  logic [3:0]    st_r, st_nxt;
  logic [2:0]    ph_r, ph_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [7:0]    plen_r, plen_nxt;
  logic [7:0]    cmd_r, cmd_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic [31:0]   sn_r, sn_nxt;
  logic [1:0]    sni_r, sni_nxt;
  logic [3:0]    ret_r, ret_nxt;   // state after result taken
  logic          ov_r, ov_nxt;
  logic [2:0]    ok_r, ok_nxt;
  logic [7:0]    od_r, od_nxt;
  logic [31:0]   osn_r, osn_nxt;
  logic          ol_r, ol_nxt;
  logic [8:0]    flen;
  logic [6:0]    emit_n;

  assign in_ready  = (st_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_kind  = ok_r;
  assign out_data_byte = od_r;
  assign out_serial_number = osn_r;
  assign out_last  = ol_r;
  // push is only issued in the accepting cycle
  assign wr_byte   = in_rx_byte;
  assign scan_pos  = pos_r;
  assign flen      = {1'b0, plen_r} + 9'd4;
  assign frame_len = flen;
  assign emit_n    = (plen_r > 8'(RESULT_CAP)) ? 7'(RESULT_CAP) : plen_r[6:0];

  always_comb begin
    st_nxt = st_r; ph_nxt = ph_r; pos_nxt = pos_r; plen_nxt = plen_r;
    cmd_nxt = cmd_r; cnt_nxt = cnt_r; sn_nxt = sn_r; sni_nxt = sni_r;
    ret_nxt = ret_r; ov_nxt = ov_r; ok_nxt = ok_r; od_nxt = od_r;
    osn_nxt = osn_r; ol_nxt = ol_r;
    cmd = '0;
    rd_addr = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          case (in_req_type)
            REQ_START: begin
              cmd.clear = 1'b1; ph_nxt = PH_FORMAT;
              ov_nxt = 1'b1; ok_nxt = KIND_FORMAT; od_nxt = '0; osn_nxt = '0;
              ol_nxt = 1'b1;
            end
            REQ_STOP: ph_nxt = PH_IDLE;
            REQ_BYTE: begin
              if (ph_r != PH_IDLE) begin
                cmd.push = 1'b1; st_nxt = S_HEAD;
              end
            end
            default: ;
          endcase
        end
      end
      S_HEAD: begin
        cmd.rd_en = 1'b1; rd_addr = '0; st_nxt = S_HCHK;
      end
      S_HCHK: begin
        if (fill == '0) st_nxt = S_IDLE;
        else if (rd_data != SYNC_BYTE) begin
          pos_nxt = CW'(1); st_nxt = S_SCAN;
        end else if (fill <= CW'(3)) st_nxt = S_IDLE;
        else begin
          cmd.rd_en = 1'b1; rd_addr = CW'(2); st_nxt = S_LEN;
        end
      end
      S_SCAN: begin
        if (pos_r >= fill) begin
          cmd.clear = 1'b1; st_nxt = S_IDLE;
        end else begin
          cmd.rd_en = 1'b1; rd_addr = pos_r; st_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        if (rd_data == SYNC_BYTE) begin
          cmd.drop_en = 1'b1; cmd.drop_scan = 1'b1; st_nxt = S_DROP;
        end else begin
          pos_nxt = pos_r + CW'(1); st_nxt = S_SCAN;
        end
      end
      S_DROP: begin
        // after resync, continue framing from the new head
        if (fill <= CW'(3)) st_nxt = S_IDLE;
        else begin
          cmd.rd_en = 1'b1; rd_addr = CW'(2); st_nxt = S_LEN;
        end
      end
      S_LEN: begin
        plen_nxt = rd_data;
        if ({1'b0, rd_data} + 9'd4 > 9'(BUFFER_BYTES)) begin
          cmd.drop_en = 1'b1; st_nxt = S_IDLE;
        end else if (9'(fill) < {1'b0, rd_data} + 9'd4) st_nxt = S_IDLE;
        else begin
          cmd.cs_clr = 1'b1; cmd.rd_en = 1'b1; rd_addr = '0;
          pos_nxt = CW'(1); st_nxt = S_CSUM;
        end
      end
      S_CSUM: begin
        cmd.cs_acc = 1'b1;
        if (pos_r == CW'(2)) cmd_nxt = rd_data;
        if (9'(pos_r) < flen) begin
          cmd.rd_en = 1'b1; rd_addr = pos_r; pos_nxt = pos_r + CW'(1);
        end else st_nxt = S_CMD;
      end
      S_CMD: begin
        if (cs != 8'h00) begin
          cmd.drop_en = 1'b1; st_nxt = S_IDLE;
        end else begin
          case (cmd_r)
            CMD_DATA: begin
              if (ph_r == PH_READY && plen_r != 8'd0) begin
                cnt_nxt = '0; cmd.rd_en = 1'b1; rd_addr = CW'(3); st_nxt = S_EMIT;
              end else begin
                cmd.drop_en = 1'b1; cmd.drop_frame = 1'b1; st_nxt = S_IDLE;
              end
            end
            CMD_ACK: begin
              cmd.rd_en = 1'b1; rd_addr = CW'(3); st_nxt = S_ST;
            end
            CMD_SERIAL: begin
              sn_nxt = '0; sni_nxt = '0;
              if (plen_r == 8'd0) begin
                ph_nxt = PH_READY; ov_nxt = 1'b1; ok_nxt = KIND_READY;
                od_nxt = '0; osn_nxt = '0; ol_nxt = 1'b1;
                cmd.drop_en = 1'b1; cmd.drop_frame = 1'b1; st_nxt = S_OUT;
                ret_nxt = S_IDLE;
              end else begin
                cmd.rd_en = 1'b1; rd_addr = CW'(3); st_nxt = S_SNRD;
              end
            end
            default: begin
              ph_nxt = PH_IDLE; cmd.clear = 1'b1;
              ov_nxt = 1'b1; ok_nxt = KIND_DROPPED; od_nxt = '0; osn_nxt = '0;
              ol_nxt = 1'b1; st_nxt = S_OUT; ret_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SNRD: begin
        sn_nxt = sn_r | ({24'd0, rd_data} << {sni_r, 3'b000});
        if (sni_r == 2'd3 || {6'd0, sni_r} + 8'd1 >= plen_r) begin
          ph_nxt = PH_READY; ov_nxt = 1'b1; ok_nxt = KIND_READY; od_nxt = '0;
          osn_nxt = sn_r | ({24'd0, rd_data} << {sni_r, 3'b000}); ol_nxt = 1'b1;
          cmd.drop_en = 1'b1; cmd.drop_frame = 1'b1; st_nxt = S_OUT;
          ret_nxt = S_IDLE;
        end else begin
          sni_nxt = sni_r + 2'd1;
          cmd.rd_en = 1'b1; rd_addr = CW'(4) + CW'(sni_r); st_nxt = S_SNRD;
        end
      end
      S_ST: begin
        cmd.drop_en = 1'b1; cmd.drop_frame = 1'b1; st_nxt = S_IDLE;
        od_nxt = '0; osn_nxt = '0; ol_nxt = 1'b1;
        if (rd_data != 8'h00) begin
          ov_nxt = 1'b1; ok_nxt = KIND_FAILED;
          st_nxt = S_OUT; ret_nxt = S_IDLE;
        end else if (ph_r == PH_FORMAT) begin
          ph_nxt = PH_MODE; ov_nxt = 1'b1; st_nxt = S_OUT; ret_nxt = S_IDLE;
          if (VALID_MODES[mode]) begin
            ok_nxt = KIND_PRESET; od_nxt = PRESET_PREFIX_XOR ^ {4'd0, mode};
          end else ok_nxt = KIND_FAILED;
        end else if (ph_r == PH_MODE) begin
          ph_nxt = PH_ID; ov_nxt = 1'b1; ok_nxt = KIND_IDREQ;
          st_nxt = S_OUT; ret_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        // wait for output slot
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1; ok_nxt = KIND_PAYLOAD; od_nxt = rd_data; osn_nxt = '0;
          if (7'(cnt_r) + 7'd1 >= emit_n) begin
            ol_nxt = 1'b1;
            cmd.drop_en = 1'b1; cmd.drop_frame = 1'b1;
            st_nxt = S_OUT; ret_nxt = S_IDLE;
          end else begin
            ol_nxt = 1'b0;
            cnt_nxt = cnt_r + 6'd1;
            cmd.rd_en = 1'b1; rd_addr = CW'(4) + CW'(cnt_r);
            st_nxt = S_EMIT;
          end
        end
      end
      S_OUT: begin
        if (!ov_r || out_ready) st_nxt = ret_r;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ph_r <= PH_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ph_r <= ph_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt; plen_r <= plen_nxt; cmd_r <= cmd_nxt; cnt_r <= cnt_nxt;
    sn_r <= sn_nxt; sni_r <= sni_nxt; ret_r <= ret_nxt; ok_r <= ok_nxt;
    od_r <= od_nxt; osn_r <= osn_nxt; ol_r <= ol_nxt;
  end
endmodule
`default_nettype wire

// ===== design/serial_dongle_frame_receiver_top.sv =====
//------------------------------------------------------------------------------
// serial_dongle_frame_receiver_top
// Deframer and link sequencer for a serial radio dongle.
//
//  channel | ports                       | direction
//  in      | in_valid/in_ready           | request, byte in
//  out     | out_valid/out_ready         | result out
//  cfg     | cfg_valid/cfg_ready         | preset mode write
//
// One item at a time. A byte is stored, then the head byte is read and
// checked; a sync head with at least four bytes also has its length read.
// A resync scan reads and checks each byte scanned, then drops; a check pass
// reads the whole frame; a result waits out any output stall. Synchronous
// active-low reset; no clearing pass. One store read port paces scan and check
// passes. Mode writes are taken only while no transaction is in flight.
//------------------------------------------------------------------------------
`default_nettype none
module serial_dongle_frame_receiver_top #(
  parameter int BUFFER_BYTES = sdfr_pkg::BufferBytesDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_data_byte,
  output logic [31:0]      out_serial_number,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_preset_mode
);
  import sdfr_pkg::*;
  localparam int CW = $clog2(BUFFER_BYTES + 1);

  logic [3:0]    mode_r;
  sdfr_cmd_t     cmd;
  logic [7:0]    wr_byte, rd_data, cs;
  logic [CW-1:0] rd_addr, scan_pos, fill;
  logic [8:0]    frame_len;

  assign cfg_ready = in_ready;
  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= 4'd1;
    else if (cfg_valid && cfg_ready) mode_r <= cfg_preset_mode;
  end

  sdfr_ctrl #(.BUFFER_BYTES(BUFFER_BYTES)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_req_type, .in_rx_byte,
    .mode(mode_r), .out_valid, .out_ready, .out_kind, .out_data_byte,
    .out_serial_number, .out_last, .cmd, .wr_byte, .rd_addr, .scan_pos,
    .frame_len, .rd_data, .fill, .cs
  );

  sdfr_datapath #(.BUFFER_BYTES(BUFFER_BYTES)) u_dp (
    .clk, .rst_n, .cmd, .wr_byte, .rd_addr, .scan_pos, .frame_len,
    .rd_data, .fill, .cs
  );
endmodule
`default_nettype wire

// ===== design/sdfr_checker.sv =====
//------------------------------------------------------------------------------
// sdfr_checker
// Port-level checks for the frame receiver.
//------------------------------------------------------------------------------
`default_nettype none
module sdfr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_kind,
  input wire logic [7:0]  out_data_byte,
  input wire logic        out_last
);
  import sdfr_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_data_byte))
    else $error("result changed while stalled");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind <= KIND_FORMAT) else $error("bad kind");

  a_nonpay_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_PAYLOAD |-> out_last)
    else $error("control result not last");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready) else $error("input taken mid-frame");
endmodule

bind serial_dongle_frame_receiver_top sdfr_checker u_chk (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready, .out_kind,
  .out_data_byte, .out_last
);
`default_nettype wire
